@@ sv/assert_macros.svh @@
// Assertion macros shared by the trajectory evaluator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PPTEV_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When cond holds, prop must hold in the following cycle.
`define PPTEV_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);

`endif

@@ sv/pptev_pkg.sv @@
// Shared types, constants and saturation helper for the piecewise quintic evaluator.
// No dependencies.
package pptev_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int VAL_W         = 48;
    localparam int TIME_W        = 32;
    localparam int COEF_W        = 6 * VAL_W;
    localparam int S_TDATA_W     = 360;
    localparam int M_TDATA_W     = 144;
    localparam int QDEPTH        = 2;
    localparam int QAW           = $clog2(QDEPTH);
    localparam int REG_NODE_COUNT = 0;
    localparam logic [3:0] LAST_STEP = 4'd11;

    localparam logic signed [55:0] S48_MAX_W = 56'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [55:0] S48_MIN_W = 56'shFF_8000_0000_0000;

    typedef enum logic [1:0] {
        K_WRITE   = 2'd0,
        K_SEARCH  = 2'd1,
        K_RESTART = 2'd2,
        K_CONT    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SPAN  = 2'd2,
        ST_WALK  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDL, S_SRCH, S_WALK, S_FETCH, S_LOAD, S_PREP, S_EVAL, S_OUT
    } state_t;

    typedef struct packed {
        kind_t                     kind;
        logic [5:0]                node_index;
        logic [TIME_W-1:0]         node_time;
        logic signed [VAL_W-1:0]   coef_a;
        logic signed [VAL_W-1:0]   coef_b;
        logic signed [VAL_W-1:0]   coef_c;
        logic signed [VAL_W-1:0]   coef_d;
        logic signed [VAL_W-1:0]   coef_e;
        logic signed [VAL_W-1:0]   coef_f;
        logic [TIME_W-1:0]         query_time;
    } item_t;

    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [55:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > S48_MAX_W) begin
            r = S48_MAX_W[VAL_W-1:0];
        end else if (v < S48_MIN_W) begin
            r = S48_MIN_W[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/pptev_front.sv @@
// Front end: unpacks and classifies input transfers into a short queue.
// Depends on pptev_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pptev_front import pptev_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,   // req_type
    // node_index, node_time, coef_a..coef_f, query_time, pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output item_t                q_item,
    output logic                 q_valid,
    input  logic                 q_pop
);

    item_t            slot_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     cnt_reg;
    item_t            item_in;
    logic             push;

    always_comb begin
        item_in.kind       = kind_t'(s_tuser);
        item_in.node_index = s_tdata[5:0];
        item_in.node_time  = s_tdata[37:6];
        item_in.coef_a     = s_tdata[85:38];
        item_in.coef_b     = s_tdata[133:86];
        item_in.coef_c     = s_tdata[181:134];
        item_in.coef_d     = s_tdata[229:182];
        item_in.coef_e     = s_tdata[277:230];
        item_in.coef_f     = s_tdata[325:278];
        item_in.query_time = s_tdata[357:326];
    end

    assign s_tready = (cnt_reg < (QAW+1)'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, q_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    `PPTEV_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= (QAW+1)'(QDEPTH), "queue overfilled")
    `PPTEV_ASSERT(a_pop_nonempty, aclk, aresetn, !q_pop || q_valid, "pop from empty queue")

endmodule

@@ sv/pptev_mac.sv @@
// Shared Horner step unit: acc*dt (Q16.16, rounded) plus coefficient, saturated.
// Partial products registered, then combine, round and add. Uses pptev_pkg.
module pptev_mac import pptev_pkg::*; (
    input  logic                    aclk,
    input  logic signed [VAL_W-1:0] acc,
    input  logic [TIME_W-1:0]       dmag,
    input  logic                    dneg,
    input  logic signed [VAL_W-1:0] coef,
    output logic signed [VAL_W-1:0] res
);

    logic [VAL_W-1:0]        ux;
    logic [63:0]             ph_reg, pl_reg;
    logic                    neg_reg;
    logic signed [VAL_W-1:0] coef_reg;
    logic [63:0]             mag;
    logic signed [VAL_W-1:0] m;
    logic signed [55:0]      sum;

    assign ux = acc[VAL_W-1] ? VAL_W'(-acc) : acc;

    always_ff @(posedge aclk) begin
        ph_reg   <= 64'(ux) * 64'(dmag[31:16]);
        pl_reg   <= 64'(ux) * 64'(dmag[15:0]);
        neg_reg  <= acc[VAL_W-1] ^ dneg;
        coef_reg <= coef;
    end

    always_comb begin
        mag = ph_reg + ((pl_reg + 64'h8000) >> 16);
        if (neg_reg) begin
            if (mag >= 64'h0000_8000_0000_0000) begin
                m = S48_MIN_W[VAL_W-1:0];
            end else begin
                m = -signed'(mag[VAL_W-1:0]);
            end
        end else begin
            if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
                m = S48_MAX_W[VAL_W-1:0];
            end else begin
                m = signed'(mag[VAL_W-1:0]);
            end
        end
        sum = 56'(coef_reg) + 56'(m);
        res = sat48(sum);
    end

endmodule

@@ sv/pptev_engine.sv @@
// Back end: node table memories, segment search and walk, Horner sequencing, result register.
// Depends on pptev_pkg, pptev_mac and assert_macros.svh.
`include "assert_macros.svh"

module pptev_engine import pptev_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [6:0]           node_count,
    input  item_t                q_item,
    input  logic                 q_valid,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [1:0]           m_tuser,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);

    state_t state_reg, state_next;
    kind_t  kind_reg;
    logic [TIME_W-1:0] t_reg, t0_reg;
    logic [AW-1:0] seg_reg, seg_next, walk_reg, walk_next;
    logic [3:0]    step_reg, step_next;
    logic          phase_reg, phase_next;

    logic [TIME_W-1:0] time_mem [MAX_NODES];
    logic [COEF_W-1:0] coef_mem [MAX_NODES];
    logic [TIME_W-1:0] time_rd_reg;
    logic [COEF_W-1:0] coef_rd_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_wa, mem_ra;

    logic signed [VAL_W-1:0] ca_reg, cb_reg, cc_reg, cd_reg, ce_reg, cf_reg;
    logic signed [VAL_W-1:0] k5f_reg, k20f_reg, k4e_reg, k12e_reg, k3d_reg, k6d_reg, k2c_reg;
    logic [TIME_W-1:0]       dmag_reg;
    logic                    dneg_reg;
    logic signed [VAL_W-1:0] hacc_reg, coef_sel, mac_res;
    logic signed [VAL_W-1:0] pos_reg, vel_reg, accel_reg;
    status_t                 status_reg;
    logic [TIME_W:0]         dt33;

    logic [NW-1:0] n;
    logic span_bad, walk_bad, walk_has_next, srch_more, later, eval_last, query_in;

    assign n = (int'(node_count) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count);
    assign span_bad      = (t_reg < t0_reg) || (t_reg > time_rd_reg);
    assign walk_bad      = int'(walk_reg) >= int'(n);
    assign walk_has_next = (int'(walk_reg) + 1) < int'(n);
    assign srch_more     = (int'(seg_reg) + 2) < int'(n);
    assign later         = t_reg > time_rd_reg;
    assign eval_last     = (step_reg == LAST_STEP) && phase_reg;
    assign query_in      = q_valid && (q_item.kind != K_WRITE);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (query_in) begin
                    state_next = (n == '0) ? S_OUT : S_RD0;
                end
            end
            S_RD0: state_next = S_RDL;
            S_RDL: begin
                if (span_bad) begin
                    state_next = S_OUT;
                end else begin
                    case (kind_reg)
                        K_SEARCH: state_next = (int'(n) > 1) ? S_SRCH : S_FETCH;
                        K_CONT: begin
                            if (walk_bad) begin
                                state_next = S_OUT;
                            end else begin
                                state_next = walk_has_next ? S_WALK : S_FETCH;
                            end
                        end
                        default: state_next = S_FETCH;
                    endcase
                end
            end
            S_SRCH:  state_next = (later && srch_more) ? S_SRCH : S_FETCH;
            S_WALK:  state_next = S_FETCH;
            S_FETCH: state_next = S_LOAD;
            S_LOAD:  state_next = S_PREP;
            S_PREP:  state_next = S_EVAL;
            S_EVAL:  state_next = eval_last ? S_OUT : S_EVAL;
            S_OUT:   state_next = m_tready ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and control
    always_comb begin
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = AW'(q_item.node_index);
        mem_ra     = seg_reg;
        seg_next   = seg_reg;
        walk_next  = walk_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        m_tvalid   = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE: begin
                mem_ra = '0;
                if (q_valid) begin
                    q_pop  = 1'b1;
                    mem_we = (q_item.kind == K_WRITE) && (int'(q_item.node_index) < MAX_NODES);
                end
            end
            S_RD0: mem_ra = AW'(int'(n) - 1);
            S_RDL: begin
                seg_next = '0;
                if (!span_bad) begin
                    case (kind_reg)
                        K_SEARCH:  mem_ra = AW'(1);
                        K_RESTART: walk_next = '0;
                        K_CONT: begin
                            seg_next = walk_reg;
                            mem_ra   = AW'(int'(walk_reg) + 1);
                        end
                        default: mem_ra = seg_reg;
                    endcase
                end
            end
            S_SRCH: begin
                if (later) begin
                    seg_next = AW'(int'(seg_reg) + 1);
                    mem_ra   = AW'(int'(seg_reg) + 2);
                end
            end
            S_WALK: begin
                if (later) begin
                    walk_next = AW'(int'(walk_reg) + 1);
                    seg_next  = AW'(int'(walk_reg) + 1);
                end
            end
            S_PREP: begin
                step_next  = '0;
                phase_next = 1'b0;
            end
            S_EVAL: begin
                phase_next = ~phase_reg;
                if (phase_reg) begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: mem_ra = seg_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            time_mem[mem_wa] <= q_item.node_time;
            coef_mem[mem_wa] <= {q_item.coef_f, q_item.coef_e, q_item.coef_d,
                                 q_item.coef_c, q_item.coef_b, q_item.coef_a};
        end
        time_rd_reg <= time_mem[mem_ra];
        coef_rd_reg <= coef_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            seg_reg   <= '0;
            walk_reg  <= '0;
            step_reg  <= '0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            walk_reg  <= walk_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        case (step_reg)
            4'd0:    coef_sel = ce_reg;
            4'd1:    coef_sel = cd_reg;
            4'd2:    coef_sel = cc_reg;
            4'd3:    coef_sel = cb_reg;
            4'd4:    coef_sel = ca_reg;
            4'd5:    coef_sel = k4e_reg;
            4'd6:    coef_sel = k3d_reg;
            4'd7:    coef_sel = k2c_reg;
            4'd8:    coef_sel = cb_reg;
            4'd9:    coef_sel = k12e_reg;
            4'd10:   coef_sel = k6d_reg;
            default: coef_sel = k2c_reg;
        endcase
    end

    assign dt33 = {1'b0, t_reg} - {1'b0, time_rd_reg};

    pptev_mac u_mac (
        .aclk (aclk),
        .acc  (hacc_reg),
        .dmag (dmag_reg),
        .dneg (dneg_reg),
        .coef (coef_sel),
        .res  (mac_res)
    );

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (query_in) begin
                    kind_reg   <= q_item.kind;
                    t_reg      <= q_item.query_time;
                    status_reg <= ST_EMPTY;
                    pos_reg    <= '0;
                    vel_reg    <= '0;
                    accel_reg  <= '0;
                end
            end
            S_RD0: t0_reg <= time_rd_reg;
            S_RDL: begin
                if (span_bad) begin
                    status_reg <= ST_SPAN;
                end else if (kind_reg == K_CONT && walk_bad) begin
                    status_reg <= ST_WALK;
                end
            end
            S_LOAD: begin
                dneg_reg <= dt33[TIME_W];
                dmag_reg <= dt33[TIME_W] ? TIME_W'(-dt33) : dt33[TIME_W-1:0];
                ca_reg   <= coef_rd_reg[0*VAL_W +: VAL_W];
                cb_reg   <= coef_rd_reg[1*VAL_W +: VAL_W];
                cc_reg   <= coef_rd_reg[2*VAL_W +: VAL_W];
                cd_reg   <= coef_rd_reg[3*VAL_W +: VAL_W];
                ce_reg   <= coef_rd_reg[4*VAL_W +: VAL_W];
                cf_reg   <= coef_rd_reg[5*VAL_W +: VAL_W];
            end
            S_PREP: begin
                k5f_reg  <= sat48(56'(cf_reg) * 56'sd5);
                k20f_reg <= sat48(56'(cf_reg) * 56'sd20);
                k4e_reg  <= sat48(56'(ce_reg) * 56'sd4);
                k12e_reg <= sat48(56'(ce_reg) * 56'sd12);
                k3d_reg  <= sat48(56'(cd_reg) * 56'sd3);
                k6d_reg  <= sat48(56'(cd_reg) * 56'sd6);
                k2c_reg  <= sat48(56'(cc_reg) * 56'sd2);
                hacc_reg <= cf_reg;
            end
            S_EVAL: begin
                if (phase_reg) begin
                    case (step_reg)
                        4'd4: begin
                            pos_reg  <= mac_res;
                            hacc_reg <= k5f_reg;
                        end
                        4'd8: begin
                            vel_reg  <= mac_res;
                            hacc_reg <= k20f_reg;
                        end
                        LAST_STEP: begin
                            accel_reg  <= mac_res;
                            status_reg <= ST_OK;
                        end
                        default: hacc_reg <= mac_res;
                    endcase
                end
            end
            default: hacc_reg <= hacc_reg;
        endcase
    end

    assign m_tuser = status_reg;
    assign m_tdata = {accel_reg, vel_reg, pos_reg};

    `PPTEV_ASSERT(a_err_zero, aclk, aresetn,
        !m_tvalid || status_reg == ST_OK || (pos_reg == '0 && vel_reg == '0 && accel_reg == '0),
        "error result carries nonzero values")
    `PPTEV_ASSERT_NEXT(a_out_done, aclk, aresetn, state_reg == S_OUT && m_tready,
        state_reg == S_IDLE, "result taken but engine did not return to idle")
    `PPTEV_ASSERT_NEXT(a_walk_hold, aclk, aresetn, state_reg != S_RDL && state_reg != S_WALK,
        $stable(walk_reg), "walk pointer moved outside a walk step")

endmodule

@@ sv/piecewise_poly_trajectory_eval_top.sv @@
// Top level of the piecewise quintic trajectory evaluator: APB register, front queue, engine.
// Depends on pptev_pkg, pptev_front and pptev_engine.
//
// Input stream s_*: tuser = req_type; a write transfer loads one table node, a query
// transfer (search, walk restart, walk continue) yields exactly one result on m_*.
// Result stream m_*: tuser = status, tdata = position, velocity, acceleration (Q24.24).
// node_count is set through the APB port at address 0, by the user only while the block is
// idle (the block does not enforce this). A two-entry queue takes input transfers while
// the engine works or a result waits. A write is stored in the idle state. A query goes
// from dequeue through the RD0/RDL reads, the search or walk steps (at most node count - 1
// for search, 1 for walk), FETCH, LOAD, PREP and the 12 Horner steps of the shared
// multiply unit to result valid. Error results (empty table, time out of span, stale
// walk) skip the evaluation. One item is in the engine at a time; a stalled m_tready
// holds the result and the engine, and the queue then fills and drops s_tready.
// Reset clears the queue, the walk pointer and node_count; table contents are
// undefined until written.
module piecewise_poly_trajectory_eval_top import pptev_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,   // req_type
    // node_index[5:0], node_time[37:6], coef_a..coef_f[325:38], query_time[357:326]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [1:0]           m_tuser,   // status
    // position[47:0], velocity[95:48], acceleration[143:96]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [6:0] node_count_reg;
    item_t      q_item;
    logic       q_valid, q_pop;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2:2] == 1'(REG_NODE_COUNT));
    assign prdata  = reg_sel ? {25'b0, node_count_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            node_count_reg <= pwdata[6:0];
        end
    end

    pptev_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    pptev_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .node_count (node_count_reg),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata)
    );

endmodule

@@ tb/piecewise_poly_trajectory_eval_top_test.sv @@
// Testbench for piecewise_poly_trajectory_eval_top: directed rows, then random phases,
// each result checked against an in-bench Q24.24 quintic predictor.
// Depends on pptev_pkg and the RTL of the evaluator.
module piecewise_poly_trajectory_eval_top_test import pptev_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint VAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam int TARGET_ITEMS = 1450;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct {
        status_t st;
        longint  pos;
        longint  vel;
        longint  acc;
    } traj_result_t;

    typedef struct {
        bit         is_cfg;
        logic [6:0] cfg_val;
        item_t      it;
        bit         fixed;
        status_t    fixed_st;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [1:0]           s_tuser;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [1:0]           m_tuser;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    piecewise_poly_trajectory_eval_top dut (.*);

    // predictor state
    logic [31:0]  node_tab [64];
    longint       coef_tab [64][6];
    int unsigned  walk_ptr;
    int unsigned  node_count_reg;

    traj_result_t expected_results[$];
    plan_row_t    plan[$];
    int           fails;
    int           items_sent;
    int           idle_mode;
    int           idle_cycles;
    bit           long_stall_done;
    traj_result_t got_exp;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic longint clip48(longint x);
        if (x > VAL_MAX) return VAL_MAX;
        if (x < VAL_MIN) return VAL_MIN;
        return x;
    endfunction

    // exact product with Q16.16 dt, rounded half away from zero, saturated
    function automatic longint mul_by_dt(longint x, longint dt);
        bit neg;
        longint unsigned ux, ud, hi, lo, mag;
        neg = (x < 0) != (dt < 0);
        ux = (x < 0) ? longint'(-x) : x;
        ud = (dt < 0) ? longint'(-dt) : dt;
        hi = (ud >> 16) & 64'hFFFF;
        lo = ud & 64'hFFFF;
        mag = ux * hi + ((ux * lo + 64'h8000) >> 16);
        if (neg) begin
            if (mag >= 64'h8000_0000_0000) return VAL_MIN;
            return -longint'(mag);
        end
        if (mag > 64'h7FFF_FFFF_FFFF) return VAL_MAX;
        return longint'(mag);
    endfunction

    function automatic longint horner(longint acc, longint dt, longint k);
        return clip48(k + mul_by_dt(acc, dt));
    endfunction

    function automatic bit eval_trajectory(input item_t it, output traj_result_t r);
        int unsigned n, seg;
        longint dt, p, v, q;
        longint c[6];
        r = '{ST_OK, 0, 0, 0};
        n = (node_count_reg > 64) ? 64 : node_count_reg;
        if (it.kind == K_WRITE) begin
            node_tab[it.node_index] = it.node_time;
            coef_tab[it.node_index][0] = it.coef_a;
            coef_tab[it.node_index][1] = it.coef_b;
            coef_tab[it.node_index][2] = it.coef_c;
            coef_tab[it.node_index][3] = it.coef_d;
            coef_tab[it.node_index][4] = it.coef_e;
            coef_tab[it.node_index][5] = it.coef_f;
            return 1'b0;
        end
        if (n == 0) begin
            r.st = ST_EMPTY;
            return 1'b1;
        end
        if (it.query_time < node_tab[0] || it.query_time > node_tab[n-1]) begin
            r.st = ST_SPAN;
            return 1'b1;
        end
        case (it.kind)
            K_SEARCH: begin
                seg = 0;
                while (seg + 1 < n && it.query_time > node_tab[seg+1]) seg++;
            end
            K_RESTART: begin
                walk_ptr = 0;
                seg = 0;
            end
            default: begin
                if (walk_ptr >= n) begin
                    r.st = ST_WALK;
                    return 1'b1;
                end
                if (walk_ptr + 1 < n && it.query_time > node_tab[walk_ptr+1]) walk_ptr++;
                seg = walk_ptr;
            end
        endcase
        dt = longint'(it.query_time) - longint'(node_tab[seg]);
        c = coef_tab[seg];
        p = c[5];
        for (int i = 4; i >= 0; i--) p = horner(p, dt, c[i]);
        v = clip48(5 * c[5]);
        v = horner(v, dt, clip48(4 * c[4]));
        v = horner(v, dt, clip48(3 * c[3]));
        v = horner(v, dt, clip48(2 * c[2]));
        v = horner(v, dt, c[1]);
        q = clip48(20 * c[5]);
        q = horner(q, dt, clip48(12 * c[4]));
        q = horner(q, dt, clip48(6 * c[3]));
        q = horner(q, dt, clip48(2 * c[2]));
        r.pos = p;
        r.vel = v;
        r.acc = q;
        return 1'b1;
    endfunction

    function automatic logic signed [47:0] rand_coef();
        logic signed [63:0] w;
        case ($urandom_range(0, 9))
            0: return 48'sh7FFF_FFFF_FFFF;
            1: return 48'sh8000_0000_0000;
            2, 3: return 48'({$urandom, $urandom});
            default: begin
                w = $signed({$urandom, $urandom});
                return 48'(w >>> $urandom_range(16, 40));
            end
        endcase
    endfunction

    function automatic logic [31:0] seg_time(int unsigned j, int unsigned n);
        logic [31:0] lo;
        lo = node_tab[j];
        if (j + 1 < n && node_tab[j+1] > lo) return lo + $urandom_range(0, node_tab[j+1] - lo);
        return lo;
    endfunction

    function automatic logic [31:0] pick_time(int unsigned n);
        if (n == 0 || $urandom_range(0, 9) == 0) return $urandom;
        return seg_time($urandom_range(0, n - 1), n);
    endfunction

    function automatic item_t make_item(kind_t k);
        item_t it;
        it = '0;
        it.kind = k;
        it.node_index = 6'($urandom);
        it.node_time = $urandom;
        it.query_time = $urandom;
        return it;
    endfunction

    function automatic void add_write(logic [5:0] idx, logic [31:0] t,
                                      logic signed [47:0] a, logic signed [47:0] b,
                                      logic signed [47:0] c, logic signed [47:0] d,
                                      logic signed [47:0] e, logic signed [47:0] f);
        plan_row_t row;
        row = '{0, 0, make_item(K_WRITE), 0, ST_OK};
        row.it.node_index = idx;
        row.it.node_time = t;
        row.it.coef_a = a;
        row.it.coef_b = b;
        row.it.coef_c = c;
        row.it.coef_d = d;
        row.it.coef_e = e;
        row.it.coef_f = f;
        plan = {plan, row};
    endfunction

    function automatic void add_query(kind_t k, logic [31:0] t, bit fixed = 0,
                                      status_t st = ST_OK);
        plan_row_t row;
        row = '{0, 0, make_item(k), fixed, st};
        row.it.query_time = t;
        plan = {plan, row};
    endfunction

    function automatic void add_cfg(logic [6:0] v);
        plan_row_t row;
        row = '{1, v, '0, 0, ST_OK};
        plan = {plan, row};
    endfunction

    task automatic send_item(item_t it, bit fixed = 0, status_t fst = ST_OK);
        traj_result_t r;
        int gap;
        gap = 0;
        if (idle_mode != 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8: gap = $urandom_range(1, 3);
                default: gap = $urandom_range(10, 40);
            endcase
        end
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {2'b00, it.query_time, it.coef_f, it.coef_e, it.coef_d, it.coef_c,
                    it.coef_b, it.coef_a, it.node_time, it.node_index};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (eval_trajectory(it, r)) begin
            if (fixed) r = '{fst, 0, 0, 0};
            expected_results = {expected_results, r};
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic apb_write(logic [6:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(REG_NODE_COUNT * 4);
        pwdata <= {25'd0, v};
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        node_count_reg = v;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reload_nodes(int unsigned upto, bit ordered);
        logic [32:0] t;
        item_t it;
        t = ($urandom_range(0, 3) == 0) ? 33'($urandom) : 33'($urandom_range(0, 16'hFFFF));
        for (int unsigned i = 0; i < upto; i++) begin
            it = make_item(K_WRITE);
            it.node_index = 6'(i);
            if (ordered) begin
                t = t + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'h0100_0000)
                                                      : $urandom_range(0, 32'h0004_0000));
                if (t > 33'hFFFF_FFFF) t = 33'hFFFF_FFFF;
                it.node_time = t[31:0];
            end
            it.coef_a = rand_coef();
            it.coef_b = rand_coef();
            it.coef_c = rand_coef();
            it.coef_d = rand_coef();
            it.coef_e = rand_coef();
            it.coef_f = rand_coef();
            send_item(it);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation pending");
                fails++;
            end else begin
                got_exp = expected_results.pop_front();
                if (m_tuser !== got_exp.st) begin
                    $error("status: expected %0d, got %0d", got_exp.st, m_tuser);
                    fails++;
                end
                if (m_tdata[47:0] !== got_exp.pos[47:0]) begin
                    $error("position: expected %h, got %h", got_exp.pos[47:0], m_tdata[47:0]);
                    fails++;
                end
                if (m_tdata[95:48] !== got_exp.vel[47:0]) begin
                    $error("velocity: expected %h, got %h", got_exp.vel[47:0], m_tdata[95:48]);
                    fails++;
                end
                if (m_tdata[143:96] !== got_exp.acc[47:0]) begin
                    $error("acceleration: expected %h, got %h", got_exp.acc[47:0],
                           m_tdata[143:96]);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result-side backpressure
    initial begin
        int hold, span, rmode;
        hold = 0;
        span = 0;
        rmode = 0;
        m_tready = 1'b0;
        long_stall_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_stall_done && items_sent >= 300) begin
                long_stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            if (span == 0) begin
                rmode = $urandom_range(0, 2);
                span = $urandom_range(50, 300);
            end
            span--;
            if (rmode == 0 || !aresetn) begin
                m_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(9, 49);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned n, neff, j, k;
        item_t it;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fails = 0;
        items_sent = 0;
        idle_cycles = 0;
        idle_mode = 1;
        walk_ptr = 0;
        node_count_reg = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        add_query(K_SEARCH, 32'h0, 1, ST_EMPTY);
        add_query(K_RESTART, 32'hFFFF_FFFF, 1, ST_EMPTY);
        add_query(K_CONT, 32'h0, 1, ST_EMPTY);
        add_write(6'd0, 32'h0001_0000, VAL_MAX[47:0], VAL_MAX[47:0], VAL_MAX[47:0],
                  VAL_MAX[47:0], VAL_MAX[47:0], VAL_MAX[47:0]);
        add_write(6'd1, 32'h0002_0000, VAL_MIN[47:0], VAL_MIN[47:0], VAL_MIN[47:0],
                  VAL_MIN[47:0], VAL_MIN[47:0], VAL_MIN[47:0]);
        add_write(6'd2, 32'h0003_0000, 48'sh1_000000, -48'sh1_000000, 48'sh0,
                  48'sh8000, -48'sh4000, 48'sh1);
        add_write(6'd3, 32'hFFFF_FFFF, 48'sh12_345678, -48'sh3_21FEDC, 48'sh7_0000,
                  48'sh1, -48'sh1, 48'sh0);
        add_write(6'd63, 32'h8000_0000, 48'sh0, 48'sh0, 48'sh0, 48'sh0, 48'sh0, 48'sh0);
        add_cfg(7'd4);
        add_query(K_SEARCH, 32'h0, 1, ST_SPAN);
        add_query(K_SEARCH, 32'h0001_0000);
        add_query(K_SEARCH, 32'h0001_8000);
        add_query(K_SEARCH, 32'h0002_8000);
        add_query(K_SEARCH, 32'hFFFF_FFFF);
        add_query(K_RESTART, 32'h0002_8000);
        add_query(K_CONT, 32'h0002_8000);
        add_query(K_CONT, 32'h0002_0000);
        add_query(K_CONT, 32'h0003_0001);
        add_query(K_CONT, 32'h0001_0000);
        add_query(K_CONT, 32'hFFFF_0000);
        add_cfg(7'd2);
        add_query(K_CONT, 32'h0001_8000, 1, ST_WALK);
        add_query(K_SEARCH, 32'h0002_0001, 1, ST_SPAN);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_idle();
                apb_write(plan[i].cfg_val);
            end else begin
                send_item(plan[i].it, plan[i].fixed, plan[i].fixed_st);
            end
        end

        reload_nodes(64, 1);
        while (items_sent < TARGET_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 2) == 0) begin
                idle_mode = $urandom_range(0, 2);
                reload_nodes($urandom_range(2, 64), $urandom_range(0, 3) != 0);
                wait_idle();
            end
            case ($urandom_range(0, 7))
                0: n = 0;
                1: n = 1;
                2: n = 2;
                3: n = 64;
                4: n = 127;
                default: n = $urandom_range(3, 63);
            endcase
            apb_write(n[6:0]);
            neff = (n > 64) ? 64 : n;
            idle_mode = $urandom_range(0, 2);
            for (int i = 0; i < 100; i++) begin
                if (items_sent >= TARGET_ITEMS) break;
                case ($urandom_range(0, 19))
                    0: begin
                        it = make_item(K_WRITE);
                        it.coef_a = rand_coef();
                        it.coef_b = rand_coef();
                        it.coef_c = rand_coef();
                        it.coef_d = rand_coef();
                        it.coef_e = rand_coef();
                        it.coef_f = rand_coef();
                        send_item(it);
                    end
                    1, 2, 3, 4, 5, 6, 7, 8: begin
                        it = make_item(K_SEARCH);
                        it.query_time = pick_time(neff);
                        send_item(it);
                    end
                    default: begin
                        it = make_item(K_RESTART);
                        it.query_time = (neff == 0) ? $urandom : seg_time(0, neff);
                        send_item(it);
                        j = 0;
                        k = $urandom_range(1, 8);
                        repeat (k) begin
                            it = make_item(K_CONT);
                            if ($urandom_range(0, 2) != 0 && j + 1 < neff) j++;
                            if (neff == 0 || $urandom_range(0, 15) == 0) begin
                                it.query_time = $urandom;
                            end else begin
                                it.query_time = seg_time(j, neff);
                            end
                            send_item(it);
                        end
                    end
                endcase
            end
        end

        wait_idle();
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
